// ===== sv/msr_pkg.sv =====
package msr_pkg;

    localparam logic [15:0] UNITY_GAIN  = 16'd32768;
    localparam logic [14:0] FULL_SCALE  = 15'd32767;

    // Direction codes, 2-bit two's complement
    localparam logic signed [1:0] DIR_NONE = 2'sb00;
    localparam logic signed [1:0] DIR_FWD  = 2'sb01;
    localparam logic signed [1:0] DIR_REV  = 2'sb11;

    // Input opcodes
    localparam logic OP_TICK    = 1'b0;
    localparam logic OP_DISABLE = 1'b1;

    // Configuration register indexes
    localparam logic [1:0] CFG_GAIN        = 2'd0;
    localparam logic [1:0] CFG_FORCE_LIMIT = 2'd1;
    localparam logic [1:0] CFG_DUTY_LIMIT  = 2'd2;
    localparam logic [1:0] CFG_SLEW_STEP   = 2'd3;

    typedef enum logic [1:0] {
        PH_DRIVE = 2'd0,
        PH_DEAD1 = 2'd1,
        PH_DEAD2 = 2'd2
    } t_phase;

    // Scaled tick handed from the input stage to the control stage
    typedef struct packed {
        logic               opcode;
        logic signed [1:0]  req;
        logic [14:0]        target;
    } t_tick;

    typedef struct packed {
        logic               done;
        logic               enable;
        logic [14:0]        duty;
        logic signed [1:0]  dir;
    } t_result;

endpackage

// ===== sv/msr_scale.sv =====
// Input stage: gain multiply, force clamp and duty target, registered.
module msr_scale (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_load,
    input  logic                 i_take,
    input  logic                 i_opcode,
    input  logic signed [15:0]   i_force,
    input  logic [15:0]          i_gain,
    input  logic [14:0]          i_force_limit,
    input  logic [14:0]          i_duty_limit,
    output logic                 o_valid,
    output msr_pkg::t_tick       o_tick
);

    logic                 r_valid;
    msr_pkg::t_tick       r_tick;
    msr_pkg::t_tick       n_tick;
    logic [15:0]          w_mag;
    logic [15:0]          w_gain;
    logic [31:0]          w_prod;
    logic [15:0]          w_scaled;
    logic [14:0]          w_clamped;

    always_comb begin
        w_mag  = i_force[15] ? 16'(~i_force + 16'sd1) : 16'(i_force);
        w_gain = (i_gain > msr_pkg::UNITY_GAIN) ? msr_pkg::UNITY_GAIN : i_gain;
        w_prod = 32'(w_mag) * 32'(w_gain);
        w_scaled = w_prod[30:15];
        w_clamped = (w_scaled > 16'(i_force_limit)) ? i_force_limit : w_scaled[14:0];

        n_tick.opcode = i_opcode;
        n_tick.target = (w_clamped > i_duty_limit) ? i_duty_limit : w_clamped;
        if (w_clamped == 15'd0) begin
            n_tick.req = msr_pkg::DIR_NONE;
        end else if (i_force[15]) begin
            n_tick.req = msr_pkg::DIR_REV;
        end else begin
            n_tick.req = msr_pkg::DIR_FWD;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_tick <= n_tick;
        end
    end

    assign o_valid = r_valid;
    assign o_tick  = r_tick;

endmodule

// ===== sv/msr_ctrl.sv =====
// Reversal sequencer, slew limiter and result register.
module msr_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  msr_pkg::t_tick       i_tick,
    input  logic [14:0]          i_slew_step,
    input  logic                 i_out_ready,
    output logic                 o_take,
    output logic                 o_out_valid,
    output msr_pkg::t_result     o_result
);

    msr_pkg::t_phase      r_phase;
    msr_pkg::t_phase      n_phase;
    logic signed [1:0]    r_cur_dir;
    logic signed [1:0]    n_cur_dir;
    logic signed [1:0]    r_pend_dir;
    logic signed [1:0]    n_pend_dir;
    logic [14:0]          r_duty;
    logic [14:0]          n_duty;
    logic                 r_out_valid;
    msr_pkg::t_result     r_result;
    msr_pkg::t_result     n_result;
    logic                 w_take;
    logic [14:0]          w_gap;
    logic [14:0]          w_step;
    logic signed [1:0]    w_dir;

    assign w_take = i_valid && (!r_out_valid || i_out_ready);

    always_comb begin
        n_phase    = r_phase;
        n_cur_dir  = r_cur_dir;
        n_pend_dir = r_pend_dir;
        n_duty     = r_duty;
        n_result   = '0;
        w_gap  = (i_tick.target > r_duty) ? (i_tick.target - r_duty)
                                          : (r_duty - i_tick.target);
        w_step = (w_gap > i_slew_step) ? i_slew_step : w_gap;
        w_dir  = (r_cur_dir == msr_pkg::DIR_NONE) ? i_tick.req : r_cur_dir;

        if (i_tick.opcode == msr_pkg::OP_DISABLE) begin
            n_phase    = msr_pkg::PH_DRIVE;
            n_cur_dir  = msr_pkg::DIR_NONE;
            n_pend_dir = msr_pkg::DIR_NONE;
            n_duty     = '0;
        end else begin
            unique case (r_phase)
                msr_pkg::PH_DEAD1: begin
                    n_phase = msr_pkg::PH_DEAD2;
                end
                msr_pkg::PH_DEAD2: begin
                    n_phase       = msr_pkg::PH_DRIVE;
                    n_cur_dir     = r_pend_dir;
                    n_result.dir  = r_pend_dir;
                    n_result.done = 1'b1;
                end
                default: begin
                    if (i_tick.req != msr_pkg::DIR_NONE && r_cur_dir != msr_pkg::DIR_NONE
                        && i_tick.req != r_cur_dir) begin
                        // opposite request: start dead time
                        n_duty     = '0;
                        n_pend_dir = i_tick.req;
                        n_phase    = msr_pkg::PH_DEAD1;
                    end else if (i_tick.req == msr_pkg::DIR_NONE || i_tick.target == 15'd0) begin
                        n_duty       = '0;
                        n_result.dir = r_cur_dir;
                    end else begin
                        n_cur_dir = w_dir;
                        n_duty    = (i_tick.target > r_duty) ? (r_duty + w_step)
                                                             : (r_duty - w_step);
                        n_result.dir    = w_dir;
                        n_result.duty   = n_duty;
                        n_result.enable = (n_duty != 15'd0);
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= msr_pkg::PH_DRIVE;
            r_cur_dir  <= msr_pkg::DIR_NONE;
            r_pend_dir <= msr_pkg::DIR_NONE;
            r_duty     <= '0;
        end else if (w_take) begin
            r_phase    <= n_phase;
            r_cur_dir  <= n_cur_dir;
            r_pend_dir <= n_pend_dir;
            r_duty     <= n_duty;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_take) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_result <= n_result;
        end
    end

    assign o_take      = w_take;
    assign o_out_valid = r_out_valid;
    assign o_result    = r_result;

endmodule

// ===== sv/motor_drive_slew_reversal_top.sv =====
// Motor drive: slew-limited PWM duty with a dead time on direction reversal.
//
// Input stream (s_axis): one item per control tick. tuser carries the opcode
// (0 tick, 1 disable), tdata the signed 16-bit force request. Every item
// gives exactly one result item on the output stream (m_axis).
// Config channel: index/data write, always ready; write only while idle.
//
// An accepted item goes into the input register, then the result register.
// Throughput: one item per cycle while the receiver does not stall. The
// first register holds the gain product, clamp and duty target; the second
// stage runs the reversal sequencer and slew limiter and loads the result
// register, so the multiplier and the slew path sit in separate cycles.
//
// Reset (i_rst_n low, synchronous) empties both stages, sets gain to unity,
// all limits to full scale and the drive state to idle with zero duty.
// When the receiver stalls, the result register holds its item and the
// input register still takes one more item; after that s_tready drops
// until the result is taken.
module motor_drive_slew_reversal_top (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // input item
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [15:0]  s_axis_tdata,   // [15:0] force_request
    input  logic         s_axis_tuser,   // [0] opcode
    // result item
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [23:0]  m_axis_tdata,   // [1:0] drive_direction, [16:2] duty,
                                         // [17] drive_enable, [18] reversal_done
    // configuration writes
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [1:0]   i_cfg_index,
    input  logic [15:0]  i_cfg_data
);

    logic [15:0]         r_gain;
    logic [14:0]         r_force_limit;
    logic [14:0]         r_duty_limit;
    logic [14:0]         r_slew_step;
    logic                w_load;
    logic                w_take;
    logic                w_tick_valid;
    msr_pkg::t_tick      w_tick;
    msr_pkg::t_result    w_result;

    // Config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain        <= msr_pkg::UNITY_GAIN;
            r_force_limit <= msr_pkg::FULL_SCALE;
            r_duty_limit  <= msr_pkg::FULL_SCALE;
            r_slew_step   <= msr_pkg::FULL_SCALE;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                msr_pkg::CFG_GAIN:        r_gain        <= i_cfg_data;
                msr_pkg::CFG_FORCE_LIMIT: r_force_limit <= i_cfg_data[14:0];
                msr_pkg::CFG_DUTY_LIMIT:  r_duty_limit  <= i_cfg_data[14:0];
                msr_pkg::CFG_SLEW_STEP:   r_slew_step   <= i_cfg_data[14:0];
                default: ;
            endcase
        end
    end

    assign o_cfg_ready   = 1'b1;
    // input register frees up whenever its item moves on this cycle
    assign s_axis_tready = !w_tick_valid || w_take;
    assign w_load        = s_axis_tvalid && s_axis_tready;

    msr_scale u_scale (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_load        (w_load),
        .i_take        (w_take),
        .i_opcode      (s_axis_tuser),
        .i_force       (s_axis_tdata),
        .i_gain        (r_gain),
        .i_force_limit (r_force_limit),
        .i_duty_limit  (r_duty_limit),
        .o_valid       (w_tick_valid),
        .o_tick        (w_tick)
    );

    msr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (w_tick_valid),
        .i_tick      (w_tick),
        .i_slew_step (r_slew_step),
        .i_out_ready (m_axis_tready),
        .o_take      (w_take),
        .o_out_valid (m_axis_tvalid),
        .o_result    (w_result)
    );

    assign m_axis_tdata = {5'd0, w_result.done, w_result.enable, w_result.duty, w_result.dir};

endmodule

// ===== sv/msr_chk.sv =====
module msr_chk (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [23:0]  m_axis_tdata
);

    // result held while stalled
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed under stall");

    // enable tracks nonzero duty
    a_enable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[17] == (m_axis_tdata[16:2] != 15'd0))
        else $error("drive_enable does not match duty");

    // reversal tick: new direction, no drive
    a_reversal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[18] |->
            m_axis_tdata[16:2] == 15'd0 && m_axis_tdata[1:0] != 2'b00)
        else $error("reversal tick drives or lacks direction");

    // direction stays in range, padding is zero
    a_dir_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[1:0] != 2'b10 && m_axis_tdata[23:19] == 5'd0)
        else $error("bad direction code or padding");

    // nothing left in flight after reset
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

endmodule

bind motor_drive_slew_reversal_top msr_chk u_msr_chk (.*);
